[sv/hss_pkg.sv]
// Package for the height map step smoother.
// Register indexes, reset values and shared types; no dependencies.
package hss_pkg;

	// Sample width of the height map
	localparam int HW = 16;

	// Configuration register indexes
	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_MAP_WIDTH   = 2'd0;
	localparam reg_index_t REG_MAP_HEIGHT  = 2'd1;
	localparam reg_index_t REG_MIN_STEP    = 2'd2;
	localparam reg_index_t REG_BLEND_ALPHA = 2'd3;

	// Reset values and geometry limits
	localparam int              MAP_WIDTH_RESET  = 1024;
	localparam logic [HW-1:0]   MAP_HEIGHT_RESET = 16'd1024;
	localparam int              MAP_MIN_SIDE     = 3;

	// h = 3a^2 - 2a^3 in Q0.32 for the reset alpha of one half
	localparam logic [31:0] H32_RESET  = 32'h8000_0000;
	// 3 * 2^16, the constant term of 3*2^16 - 2a
	localparam logic [17:0] ALPHA_THREE = 18'd196608;

	// Blend coefficient sequencer
	typedef enum logic [1:0] {
		COEF_IDLE = 2'b01,
		COEF_MULT = 2'b10
	} coef_state_t;

	// Per-pixel control carried with a beat into the blend stage
	typedef struct packed {
		logic smooth_ok;   // interior pixel with a full neighbourhood
		logic frame_last;  // last pixel of the map
	} pix_ctrl_t;

endpackage

[sv/hss_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-before-write on the same address. No dependencies.
module hss_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Read returns the old contents when both ports hit one address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

[sv/heightmap_step_smoother_unit.sv]
// Top level of the height map step smoother.
// Depends on hss_pkg and hss_ram.
//
// Takes one beat per clock while in_stall is low, sample or drain. The beat that releases
// a pixel loads the blend stage, then the output register; a pixel is released by the
// sample map_width+1 places behind it, or by a drain. The rate is one beat per cycle when
// not stalled, set by the single blend stage, in which a pixel's left neighbour is the
// result of the pixel before. Original samples sit in two copies of a window RAM of
// MAX_WIDTH+1 entries (centre and right read together), the previous row of results in a
// RAM of MAX_WIDTH entries. A blend_alpha write stalls the input during the coefficient multiply.
module heightmap_step_smoother_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_write,
	input  hss_pkg::reg_index_t cfg_index,
	input  logic [15:0]         cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [15:0]         height_in,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         height_out,
	output logic                was_smoothed,
	output logic                frame_last
);

	import hss_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);   // width value and window slot
	localparam int CW = $clog2(MAX_WIDTH);       // column index
	localparam int PW = $clog2(MAX_WIDTH + 2);   // pending count, up to width+1
	localparam int W_RESET = (MAP_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : MAP_WIDTH_RESET;

	// configuration
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [HW-1:0] min_step_q;
	logic [31:0]   h32_q;
	logic [31:0]   sq_q;
	logic [17:0]   tri_q;
	logic [49:0]   h48;
	coef_state_t   coef_state_q;
	logic          coef_busy;
	logic          geom_write;

	// position state
	logic [WW-1:0] slot_q;
	logic [WW-1:0] out_slot_q;
	logic [PW-1:0] pend_q;
	logic [CW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;
	logic [HW-1:0] last_q;
	logic [HW-1:0] left_q;

	// beat decode
	logic          in_acc;
	logic          pend_full;
	logic          pend_nz;
	logic          emit0;
	logic          slot_wrap;
	logic          out_slot_wrap;
	logic          col_last;
	logic          row_last;
	logic          interior;
	logic [WW-1:0] right_addr;

	// blend stage
	logic          s1_valid_q;
	logic          s1_adv;
	pix_ctrl_t     ctrl_s1;
	logic [CW-1:0] col_s1;
	logic [HW-1:0] down_s1;
	logic [HW-1:0] c_s1;
	logic [HW-1:0] right_s1;
	logic [HW-1:0] up_s1;
	logic [17:0]   sum4;
	logic signed [18:0] diff;
	logic signed [51:0] prod;
	logic signed [51:0] acc;
	logic          trig;
	logic [HW-1:0] val;

	// output register
	logic          out_valid_q;
	logic [HW-1:0] height_out_s2;
	logic          smoothed_s2;
	logic          last_s2;

	function automatic logic step_exceeds(logic [HW-1:0] a, logic [HW-1:0] b,
	                                      logic [HW-1:0] st);
		logic [HW-1:0] d;
		d = (a > b) ? a - b : b - a;
		return d > st;
	endfunction

	// Configuration registers
	assign geom_write = cfg_write &&
		(cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= WW'(W_RESET);
			h_q        <= MAP_HEIGHT_RESET;
			min_step_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAP_WIDTH: begin
					if (32'(cfg_data[10:0]) < MAP_MIN_SIDE) begin
						w_q <= WW'(MAP_MIN_SIDE);
					end else if (32'(cfg_data[10:0]) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data[10:0]);
					end
				end
				REG_MAP_HEIGHT: begin
					if (32'(cfg_data) < MAP_MIN_SIDE) begin
						h_q <= HW'(MAP_MIN_SIDE);
					end else begin
						h_q <= cfg_data;
					end
				end
				REG_MIN_STEP: begin
					min_step_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Blend coefficient: a^2 and 3 - 2a registered on the write, product taken in COEF_MULT
	assign h48 = 50'(sq_q) * 50'(tri_q);
	assign coef_busy = (coef_state_q != COEF_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_state_q <= COEF_IDLE;
			h32_q        <= H32_RESET;
		end else if (cfg_write && cfg_index == REG_BLEND_ALPHA) begin
			coef_state_q <= COEF_MULT;
		end else begin
			case (coef_state_q)
				COEF_MULT: begin
					h32_q        <= h48[47:16];
					coef_state_q <= COEF_IDLE;
				end
				default: begin
					coef_state_q <= COEF_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_write && cfg_index == REG_BLEND_ALPHA) begin
			sq_q  <= 32'(cfg_data) * 32'(cfg_data);
			tri_q <= ALPHA_THREE - {1'b0, cfg_data, 1'b0};
		end
	end

	// Handshake
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = coef_busy || (s1_valid_q && !s1_adv);
	assign in_acc   = in_valid && !in_stall;

	// Beat decode: a full window releases the oldest pixel, a drain releases it too
	assign pend_full     = (pend_q == PW'(w_q) + PW'(1));
	assign pend_nz       = (pend_q != '0);
	assign emit0         = command ? pend_nz : pend_full;
	assign slot_wrap     = (slot_q == w_q);
	assign out_slot_wrap = (out_slot_q == w_q);
	assign right_addr    = out_slot_wrap ? '0 : out_slot_q + WW'(1);
	assign col_last      = (out_col_q == CW'(w_q - WW'(1)));
	assign row_last      = (out_row_q == h_q - HW'(1));
	assign interior      = (out_col_q != '0) && !col_last && (out_row_q != '0) && !row_last;

	// Positions and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (geom_write) begin
			slot_q     <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (in_acc) begin
			if (!command) begin
				slot_q <= slot_wrap ? '0 : slot_q + WW'(1);
				if (!pend_full) begin
					pend_q <= pend_q + PW'(1);
				end
			end else if (pend_nz) begin
				pend_q <= pend_q - PW'(1);
			end
			if (emit0) begin
				out_slot_q <= out_slot_wrap ? '0 : out_slot_q + WW'(1);
				if (col_last) begin
					out_col_q <= '0;
					out_row_q <= row_last ? '0 : out_row_q + HW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && emit0) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Window of original samples: centre copy and right-neighbour copy
	hss_ram #(.DATA_W(HW), .DEPTH(MAX_WIDTH + 1)) u_win_centre (
		.clk   (clk),
		.we    (in_acc && !command),
		.waddr (slot_q),
		.wdata (height_in),
		.re    (in_acc && emit0),
		.raddr (out_slot_q),
		.rdata (c_s1)
	);

	hss_ram #(.DATA_W(HW), .DEPTH(MAX_WIDTH + 1)) u_win_right (
		.clk   (clk),
		.we    (in_acc && !command),
		.waddr (slot_q),
		.wdata (height_in),
		.re    (in_acc && emit0),
		.raddr (right_addr),
		.rdata (right_s1)
	);

	// Previous row of results, gives the up neighbour
	hss_ram #(.DATA_W(HW), .DEPTH(MAX_WIDTH)) u_row (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (val),
		.re    (in_acc && emit0),
		.raddr (out_col_q),
		.rdata (up_s1)
	);

	// Blend: h*c + (1-h)*S/4 as (h*(4c - S) + S*2^32) / 2^34
	assign sum4 = 18'(up_s1) + 18'(left_q) + 18'(right_s1) + 18'(down_s1);
	assign diff = $signed({1'b0, c_s1, 2'b00}) - $signed({1'b0, sum4});
	assign prod = $signed({1'b0, h32_q}) * diff;
	assign acc  = prod + $signed({2'b00, sum4, 32'b0});

	assign trig = ctrl_s1.smooth_ok &&
		(step_exceeds(up_s1, c_s1, min_step_q) || step_exceeds(left_q, c_s1, min_step_q) ||
		 step_exceeds(right_s1, c_s1, min_step_q) || step_exceeds(down_s1, c_s1, min_step_q));
	assign val  = trig ? acc[49:34] : c_s1;

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc && !command) begin
			last_q <= height_in;
		end
		if (in_acc && emit0) begin
			down_s1            <= last_q;
			col_s1             <= out_col_q;
			ctrl_s1.smooth_ok  <= !command && interior;
			ctrl_s1.frame_last <= col_last && row_last;
		end
		if (s1_adv) begin
			left_q        <= val;
			height_out_s2 <= val;
			smoothed_s2   <= trig;
			last_s2       <= ctrl_s1.frame_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign height_out   = height_out_s2;
	assign was_smoothed = smoothed_s2;
	assign frame_last   = last_s2;

endmodule

[tb/sv/heightmap_step_smoother_unit_tb.sv]
// Testbench for the height map step smoother: directed and random raster streams.
// Predicts every released pixel in a scoreboard class and checks it beat by beat.
// Depends on hss_pkg and heightmap_step_smoother_unit.
module heightmap_step_smoother_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hss_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int ALPHA_RESET    = 32768;
	localparam int LATENCY_PAD    = 8;
	localparam int HOLD_OFF_BEATS = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_BEATS   = 400;

	// Input commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	// How a phase picks its heights
	typedef enum int {
		HEIGHTS_RANDOM,
		HEIGHTS_NEAR,
		HEIGHTS_EXTREME
	} height_mode_t;

	// Predicts the released pixels and holds them until they come out
	class smoother_scoreboard;
		typedef struct packed {
			logic [15:0] height;
			logic        smoothed;
			logic        last;
		} pixel_t;

		bit [15:0]   orig_win [MAX_W+1];
		bit [15:0]   upd_row [MAX_W];
		int unsigned map_width, map_height, min_step, blend_alpha;
		int unsigned out_col, out_row, slot, pending;
		pixel_t      expected_px[$];
		int unsigned mismatches, pixels_checked, smoothed_seen, frames_seen;
		int unsigned drained, useful_beats;

		function new();
			map_width   = MAP_WIDTH_RESET;
			map_height  = MAP_HEIGHT_RESET;
			min_step    = 0;
			blend_alpha = ALPHA_RESET;
			clear_positions();
		endfunction

		function void clear_positions();
			out_col = 0;
			out_row = 0;
			slot    = 0;
			pending = 0;
		endfunction

		function int unsigned eff_w();
			if (map_width < MAP_MIN_SIDE) return MAP_MIN_SIDE;
			if (map_width > MAX_W) return MAX_W;
			return map_width;
		endfunction

		function int unsigned eff_h();
			return (map_height < MAP_MIN_SIDE) ? MAP_MIN_SIDE : map_height;
		endfunction

		function int outstanding();
			return expected_px.size();
		endfunction

		function void write_reg(reg_index_t idx, logic [15:0] value);
			case (idx)
				REG_MAP_WIDTH: begin
					map_width = value & 16'h07FF;
					clear_positions();
				end
				REG_MAP_HEIGHT: begin
					map_height = value;
					clear_positions();
				end
				REG_MIN_STEP: begin
					min_step = value;
				end
				REG_BLEND_ALPHA: begin
					blend_alpha = value;
				end
				default: begin
				end
			endcase
		endfunction

		function int unsigned height_gap(int unsigned x, int unsigned y);
			return (x > y) ? x - y : y - x;
		endfunction

		// h = 3a^2 - 2a^3 in Q0.32, then centre weighted by h against the mean
		function int unsigned blend(int unsigned centre, int unsigned sum4);
			longint unsigned a, h48, h32, acc;
			a   = blend_alpha;
			h48 = a * a * (64'd196608 - 64'd2 * a);
			h32 = h48 >> 16;
			acc = h32 * 64'd4 * centre + ((64'd1 << 32) - h32) * sum4;
			return int'((acc >> 34) & 64'hFFFF);
		endfunction

		// Pixel at the output position; only full neighbourhoods may smooth
		function pixel_t release_pixel(int unsigned centre, bit full, int unsigned right,
				int unsigned down);
			pixel_t      px;
			int unsigned w, hgt, up, left;
			w           = eff_w();
			hgt         = eff_h();
			px.height   = 16'(centre);
			px.smoothed = 1'b0;
			if (full && out_row > 0 && out_row + 1 < hgt && out_col > 0 && out_col + 1 < w) begin
				up   = upd_row[out_col];
				left = upd_row[out_col-1];
				if (height_gap(up, centre) > min_step || height_gap(left, centre) > min_step ||
						height_gap(right, centre) > min_step ||
						height_gap(down, centre) > min_step) begin
					px.height   = 16'(blend(centre, up + left + right + down));
					px.smoothed = 1'b1;
				end
			end
			upd_row[out_col] = px.height;
			px.last = (out_row + 1 == hgt && out_col + 1 == w);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
				if (out_row >= hgt) out_row = 0;
			end
			return px;
		endfunction

		// Accepted input beat: sample or drain
		function void note_beat(logic cmd, logic [15:0] value);
			int unsigned w, depth;
			w     = eff_w();
			depth = w + 1;
			if (cmd == CMD_DRAIN) begin
				if (pending == 0) return;
				expected_px.push_back(release_pixel(orig_win[(slot + depth - pending) % depth],
					1'b0, 0, 0));
				pending--;
				drained++;
				useful_beats++;
				return;
			end
			useful_beats++;
			if (pending >= depth)
				expected_px.push_back(release_pixel(orig_win[slot], 1'b1,
					orig_win[(slot + 1) % depth], orig_win[(slot + w) % depth]));
			else
				pending++;
			orig_win[slot] = value;
			slot = (slot + 1) % depth;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
		endfunction

		// Output beat against the oldest prediction
		function void check_pixel(logic [15:0] height, logic smoothed, logic last);
			pixel_t px;
			if (expected_px.size() == 0) begin
				report($sformatf("unexpected pixel: height %0d smoothed %0b last %0b",
					height, smoothed, last));
				return;
			end
			px = expected_px.pop_front();
			pixels_checked++;
			if (px.smoothed) smoothed_seen++;
			if (px.last) frames_seen++;
			if (height !== px.height || smoothed !== px.smoothed || last !== px.last)
				report($sformatf({"pixel %0d mismatch: expected height %0d smoothed %0b ",
					"last %0b, got height %0d smoothed %0b last %0b"}, pixels_checked,
					px.height, px.smoothed, px.last, height, smoothed, last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	reg_index_t  cfg_index = REG_MAP_WIDTH;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_SAMPLE;
	logic [15:0] height_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] height_out;
	logic        was_smoothed;
	logic        frame_last;

	smoother_scoreboard sb;
	bit          tx_gaps = 1'b0;
	bit          rx_gaps = 1'b0;
	bit          pressure_req = 1'b0;
	int unsigned near_base, near_spread;

	heightmap_step_smoother_unit #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.height_in   (height_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.height_out  (height_out),
		.was_smoothed(was_smoothed),
		.frame_last  (frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] next_height(height_mode_t mode);
		int unsigned v;
		case (mode)
			HEIGHTS_NEAR: begin
				v = near_base + $urandom_range(0, near_spread);
				if (v > 65535) v = 65535;
			end
			HEIGHTS_EXTREME: begin
				if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 65535);
				else v = $urandom_range(0, 1) ? 65535 : 0;
			end
			default: begin
				v = $urandom_range(0, 65535);
			end
		endcase
		return v[15:0];
	endfunction

	// Beat monitors
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_beat(command, height_in);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_pixel(height_out, was_smoothed, frame_last);
	end

	// Receiver: random stalls, and a long hold-off on request
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_BEATS - 1) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
				out_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: cycles with work waiting but no beat moving
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(!in_valid && sb.outstanding() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[%0t] timeout: no beat for %0d cycles, %0d pixels outstanding", $realtime,
			WATCHDOG_LIMIT, sb.outstanding());
		$display("Verification failed");
		$finish;
	end

	task automatic send_beat(input logic cmd, input logic [15:0] value);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		height_in <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[15:0];
		@(posedge clk);
		sb.write_reg(idx, value[15:0]);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every predicted pixel, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
	endtask

	// Whole frames back to back, then drains to flush the tail
	task automatic run_frames(input int unsigned frames, input height_mode_t mode);
		int unsigned total, flush;
		total = frames * sb.eff_w() * sb.eff_h();
		flush = sb.eff_w() + 1 + $urandom_range(0, 2);
		for (int unsigned i = 0; i < total; i++) send_beat(CMD_SAMPLE, next_height(mode));
		for (int unsigned i = 0; i < flush; i++) send_beat(CMD_DRAIN, next_height(mode));
	endtask

	// Samples and drains mixed at random
	task automatic run_noise(input int unsigned n, input height_mode_t mode);
		for (int unsigned i = 0; i < n; i++)
			send_beat(($urandom_range(0, 99) < 15) ? CMD_DRAIN : CMD_SAMPLE, next_height(mode));
	endtask

	initial begin : stimulus
		int unsigned  beat_goal, phase_no, w, h, r, widest;
		height_mode_t mode;
		bit           held_off;
		sb = new();
		held_off = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: drain with nothing pending, window filling, then a geometry write drops it
		send_beat(CMD_DRAIN, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'h0000);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		settle();
		set_geometry(3, 3);
		// 3x3 frame: low centre ringed by full-scale neighbours, tail flushed by drains
		send_beat(CMD_SAMPLE, 16'h0000);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'h0000);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'h0000);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'h0000);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		repeat (4) send_beat(CMD_DRAIN, 16'h0000);
		settle();
		// Interior pixel released by a drain passes through
		write_reg(REG_BLEND_ALPHA, 0);
		send_beat(CMD_SAMPLE, 16'h1234);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'h0000);
		send_beat(CMD_SAMPLE, 16'hFFFF);
		send_beat(CMD_SAMPLE, 16'h0001);
		repeat (4) send_beat(CMD_DRAIN, 16'h0000);
		settle();

		// Widest map: enough samples to wrap the window and release the start of the first row
		write_reg(REG_MIN_STEP, $urandom_range(0, 300));
		write_reg(REG_BLEND_ALPHA, $urandom_range(0, 65535));
		widest = $urandom_range(0, 1) ? MAX_W : 2047;
		set_geometry(widest, 3);
		near_spread = 600;
		near_base   = $urandom_range(0, 65535 - near_spread);
		tx_gaps     = 1'b1;
		rx_gaps     = 1'b1;
		for (int unsigned i = 0; i < MAX_W + 16; i++)
			send_beat(CMD_SAMPLE, next_height(HEIGHTS_NEAR));
		settle();

		// Random phases
		beat_goal = sb.useful_beats + RANDOM_BEATS;
		phase_no  = 0;
		while (sb.useful_beats < beat_goal || !held_off) begin
			phase_no++;
			if (phase_no == 1 || $urandom_range(0, 9) < 7 || sb.eff_w() > 40 ||
					sb.eff_h() > 16) begin
				r = $urandom_range(0, 9);
				if (r == 0) w = $urandom_range(0, 2);
				else if (r == 9) w = 3;
				else if (r == 8) w = $urandom_range(13, 40);
				else w = $urandom_range(3, 12);
				r = $urandom_range(0, 19);
				if (r == 0) h = $urandom_range(0, 2);
				else if (r == 1) h = 65535;
				else if (r < 4) h = $urandom_range(9, 16);
				else h = $urandom_range(3, 8);
				set_geometry(w, h);
			end
			if ($urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 5);
				write_reg(REG_MIN_STEP, (r == 0) ? 0 : (r == 1) ? 65535 :
					(r < 4) ? $urandom_range(0, 2000) : $urandom_range(0, 65535));
			end
			if ($urandom_range(0, 2) == 0) begin
				r = $urandom_range(0, 5);
				write_reg(REG_BLEND_ALPHA, (r == 0) ? 0 : (r == 1) ? 65535 :
					(r == 2) ? ALPHA_RESET : $urandom_range(0, 65535));
			end
			mode        = height_mode_t'($urandom_range(0, 2));
			near_spread = (sb.min_step > 30000) ? 65535 : 2 * sb.min_step + 4;
			near_base   = (near_spread >= 65535) ? 0 : $urandom_range(0, 65535 - near_spread);
			tx_gaps     = ($urandom_range(0, 3) != 0);
			rx_gaps     = ($urandom_range(0, 3) != 0);
			// Long receiver hold-off while the sender keeps pushing whole frames
			if (sb.eff_h() <= 16 && (!held_off || phase_no % 25 == 0)) begin
				tx_gaps      = 1'b0;
				pressure_req = 1'b1;
				held_off     = 1'b1;
			end
			if (sb.eff_h() > 16)
				run_noise($urandom_range(8, 3 * sb.eff_w() + 8), mode);
			else if ($urandom_range(0, 4) != 0 || pressure_req)
				run_frames((sb.eff_w() * sb.eff_h() > 100) ? 1 : $urandom_range(1, 3), mode);
			else
				run_noise($urandom_range(8, 3 * sb.eff_w() + 8), mode);
			settle();
		end

		$display("Covered %0d pixels: %0d smoothed, %0d drained, %0d frame ends", sb.pixels_checked,
			sb.smoothed_seen, sb.drained, sb.frames_seen);
		$display("Random phases: %0d, widest map register %0d, %0d mismatches", phase_no, widest,
			sb.mismatches);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
